FILE: design/rmq_pkg.sv
// shared widths, constants and codes of the rotation matrix to quaternion unit
// no dependencies; every other file of the block imports it
`default_nettype none
package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 18;                 // matrix entries, signed
    localparam int W_W       = 17;                 // scalar part, unsigned
    localparam int SUM_W     = IN_W + 4;           // trace combinations, signed
    localparam int D_W       = IN_W + 1;           // magnitude of one combination
    localparam int S_W       = IN_W + 1;           // off-diagonal sum or difference
    localparam int SHIFT     = FRAC_BITS - 2;
    localparam int RAD_W     = 2 * ((D_W + SHIFT + 1) / 2);  // even radicand width
    localparam int ROOT_W    = RAD_W / 2;
    localparam int NUM_W     = S_W + SHIFT;        // scaled dividend
    localparam int QUO_W     = NUM_W - SHIFT - 1;  // quotient bits, divisor >= ONE/2
    localparam int REM_W     = ROOT_W + 3;         // square root remainder
    localparam int Q_W       = QUO_W + 1;          // signed component before clamp
    localparam int ONE       = 1 << FRAC_BITS;

    typedef logic [1:0] best_t;
    localparam best_t BEST_X = 2'd0;
    localparam best_t BEST_Y = 2'd1;
    localparam best_t BEST_Z = 2'd2;
    localparam best_t BEST_W = 2'd3;

    typedef struct packed {
        best_t                   best;
        logic [2:0]              neg;
        logic [2:0][NUM_W-1:0]   mag;
    } front_side_t;

    typedef struct packed {
        best_t                   best;
        logic [2:0]              neg;
        logic [ROOT_W-1:0]       qb;
    } div_side_t;

endpackage
`default_nettype wire

FILE: design/rmq_front.sv
// front end: trace combinations, largest pick and off-diagonal terms, two stages
// depends on rmq_pkg
`default_nettype none
module rmq_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m00,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m10,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m20,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m01,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m11,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m21,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m02,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m12,
    input  wire logic signed [rmq_pkg::IN_W-1:0]     m22,
    output logic                                     out_valid,
    output logic [rmq_pkg::RAD_W-1:0]                rad,
    output rmq_pkg::front_side_t                     side
);
    import rmq_pkg::*;

    function automatic logic [D_W-1:0] abs_d(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] a;
        a = (v < 0) ? -v : v;
        return a[D_W-1:0];
    endfunction

    function automatic logic [S_W-1:0] abs_s(input logic signed [S_W-1:0] v);
        return (v < 0) ? S_W'(-v) : S_W'(v);
    endfunction

    logic signed [SUM_W-1:0] e00, e10, e20, e01, e11, e21, e02, e12, e22, one_s;
    logic signed [SUM_W-1:0] c0, c1, c2, c3;
    logic signed [SUM_W-1:0] t01p, t02p, t12p, t12m, t20m, t01m;

    logic                    v1_reg;
    logic [3:0][D_W-1:0]     d_reg;
    logic signed [S_W-1:0]   p01_reg, p02_reg, p12_reg, n12_reg, n20_reg, n01_reg;

    always_comb
    begin
        one_s = SUM_W'(ONE);
        e00 = SUM_W'(m00); e10 = SUM_W'(m10); e20 = SUM_W'(m20);
        e01 = SUM_W'(m01); e11 = SUM_W'(m11); e21 = SUM_W'(m21);
        e02 = SUM_W'(m02); e12 = SUM_W'(m12); e22 = SUM_W'(m22);
        c0 = one_s + e00 - e11 - e22;
        c1 = one_s - e00 + e11 - e22;
        c2 = one_s - e00 - e11 + e22;
        c3 = one_s + e00 + e11 + e22;
        t01p = e01 + e10;
        t02p = e02 + e20;
        t12p = e12 + e21;
        t12m = e12 - e21;
        t20m = e20 - e02;
        t01m = e01 - e10;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= {abs_d(c3), abs_d(c2), abs_d(c1), abs_d(c0)};
            p01_reg <= t01p[S_W-1:0];
            p02_reg <= t02p[S_W-1:0];
            p12_reg <= t12p[S_W-1:0];
            n12_reg <= t12m[S_W-1:0];
            n20_reg <= t20m[S_W-1:0];
            n01_reg <= t01m[S_W-1:0];
        end
    end

    // second stage: pick the largest, first wins on a tie
    best_t                   best;
    logic [D_W-1:0]          dmax;
    logic signed [S_W-1:0]   s0, s1, s2;

    always_comb
    begin
        best = BEST_X;
        dmax = d_reg[0];
        if (d_reg[1] > dmax)
        begin
            best = BEST_Y;
            dmax = d_reg[1];
        end
        if (d_reg[2] > dmax)
        begin
            best = BEST_Z;
            dmax = d_reg[2];
        end
        if (d_reg[3] > dmax)
        begin
            best = BEST_W;
            dmax = d_reg[3];
        end
        unique case (best)
            BEST_X:
            begin
                s0 = p01_reg; s1 = p02_reg; s2 = n12_reg;
            end
            BEST_Y:
            begin
                s0 = p01_reg; s1 = p12_reg; s2 = n20_reg;
            end
            BEST_Z:
            begin
                s0 = p02_reg; s1 = p12_reg; s2 = n01_reg;
            end
            default:
            begin
                s0 = n12_reg; s1 = n20_reg; s2 = n01_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad       <= {{(RAD_W - D_W - SHIFT){1'b0}}, dmax, {SHIFT{1'b0}}};
            side.best <= best;
            side.neg  <= {s2[S_W-1], s1[S_W-1], s0[S_W-1]};
            side.mag  <= {{abs_s(s2), {SHIFT{1'b0}}},
                          {abs_s(s1), {SHIFT{1'b0}}},
                          {abs_s(s0), {SHIFT{1'b0}}}};
        end
    end

endmodule
`default_nettype wire

FILE: design/rmq_sqrt.sv
// pipelined integer square root, one result bit per stage, sideband travels along
// depends on rmq_pkg
`default_nettype none
module rmq_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [rmq_pkg::RAD_W-1:0]     rad,
    input  wire logic [SIDE_W-1:0]             side_in,
    output logic                               out_valid,
    output logic [rmq_pkg::ROOT_W-1:0]         root,
    output logic [SIDE_W-1:0]                  side_out
);
    import rmq_pkg::*;

    localparam int LAST = ROOT_W - 1;

    logic                v_reg    [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [SIDE_W-1:0]   side_reg [ROOT_W];
    logic [REM_W-1:0]    rem_reg  [LAST];
    logic [RAD_W-1:0]    x_reg    [LAST];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic                v_in;
        logic [ROOT_W-1:0]   root_in;
        logic [SIDE_W-1:0]   side_i;
        logic [REM_W-1:0]    rem_in;
        logic [RAD_W-1:0]    x_in;
        logic [REM_W-1:0]    rem_sh;
        logic [REM_W-1:0]    trial;
        logic [REM_W-1:0]    rem_nx;
        logic [ROOT_W-1:0]   root_nx;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign root_in = '0;
            assign side_i  = side_in;
            assign rem_in  = '0;
            assign x_in    = rad;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_i  = side_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign x_in    = x_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[REM_W-3:0], x_in[RAD_W-1 -: 2]};
            trial  = REM_W'({root_in, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_nx  = rem_sh - trial;
                root_nx = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_nx  = rem_sh;
                root_nx = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[i] <= root_nx;
                side_reg[i] <= side_i;
            end
        end

        if (i < LAST)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_nx;
                    x_reg[i]   <= {x_in[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = v_reg[LAST];
    assign root      = root_reg[LAST];
    assign side_out  = side_reg[LAST];

endmodule
`default_nettype wire

FILE: design/rmq_div.sv
// three-lane pipelined restoring divider with round-to-nearest bias,
// one quotient bit per stage; depends on rmq_pkg
`default_nettype none
module rmq_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic [2:0][rmq_pkg::NUM_W-1:0]       mag,
    input  wire logic [rmq_pkg::ROOT_W-1:0]           qb,
    input  wire logic [SIDE_W-1:0]                    side_in,
    output logic                                      out_valid,
    output logic [2:0][rmq_pkg::QUO_W-1:0]            quo,
    output logic [SIDE_W-1:0]                         side_out
);
    import rmq_pkg::*;

    localparam int LAST = QUO_W - 1;
    localparam int HI_W = NUM_W - QUO_W;

    // bias stage
    logic                       nv_reg;
    logic [2:0][NUM_W-1:0]      num_reg;
    logic [ROOT_W-1:0]          nqb_reg;
    logic [SIDE_W-1:0]          nside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= 1'b0;
        end
        else if (en)
        begin
            nv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= mag[k] + NUM_W'(qb >> 1);
            end
            nqb_reg   <= qb;
            nside_reg <= side_in;
        end
    end

    logic                       v_reg    [QUO_W];
    logic [2:0][QUO_W-1:0]      quo_reg  [QUO_W];
    logic [SIDE_W-1:0]          side_reg [QUO_W];
    logic [2:0][ROOT_W-1:0]     rem_reg  [LAST];
    logic [2:0][QUO_W-1:0]      low_reg  [LAST];
    logic [ROOT_W-1:0]          qb_reg   [LAST];

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        logic                       v_in;
        logic [2:0][QUO_W-1:0]      quo_in;
        logic [SIDE_W-1:0]          side_i;
        logic [2:0][ROOT_W-1:0]     rem_in;
        logic [2:0][QUO_W-1:0]      low_in;
        logic [ROOT_W-1:0]          qb_in;
        logic [2:0][ROOT_W:0]       sh;
        logic [2:0][ROOT_W-1:0]     rem_nx;
        logic [2:0][QUO_W-1:0]      quo_nx;

        if (j == 0)
        begin : g_first
            assign v_in   = nv_reg;
            assign quo_in = '0;
            assign side_i = nside_reg;
            assign qb_in  = nqb_reg;
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign rem_in[k] = {{(ROOT_W - HI_W){1'b0}}, num_reg[k][NUM_W-1:QUO_W]};
                assign low_in[k] = num_reg[k][QUO_W-1:0];
            end
        end
        else
        begin : g_rest
            assign v_in   = v_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign side_i = side_reg[j-1];
            assign qb_in  = qb_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign low_in = low_reg[j-1];
        end

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                sh[k] = {rem_in[k], low_in[k][QUO_W-1]};
                if (sh[k] >= {1'b0, qb_in})
                begin
                    rem_nx[k] = ROOT_W'(sh[k] - {1'b0, qb_in});
                    quo_nx[k] = {quo_in[k][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_nx[k] = sh[k][ROOT_W-1:0];
                    quo_nx[k] = {quo_in[k][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j]  <= quo_nx;
                side_reg[j] <= side_i;
            end
        end

        if (j < LAST)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_nx;
                    qb_reg[j]  <= qb_in;
                    for (int k = 0; k < 3; k++)
                    begin
                        low_reg[j][k] <= {low_in[k][QUO_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[LAST];
    assign quo       = quo_reg[LAST];
    assign side_out  = side_reg[LAST];

endmodule
`default_nettype wire

FILE: design/rmq_back.sv
// back end: places components, normalizes the sign of w, clamps, output register
// depends on rmq_pkg
`default_nettype none
module rmq_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire rmq_pkg::div_side_t                 side,
    input  wire logic [2:0][rmq_pkg::QUO_W-1:0]     quo,
    output logic                                    out_valid,
    output logic signed [rmq_pkg::IN_W-1:0]         quat_x,
    output logic signed [rmq_pkg::IN_W-1:0]         quat_y,
    output logic signed [rmq_pkg::IN_W-1:0]         quat_z,
    output logic [rmq_pkg::W_W-1:0]                 quat_w,
    output logic                                    saturated
);
    import rmq_pkg::*;

    logic signed [Q_W-1:0] o0, o1, o2, big, one_q;
    logic signed [Q_W-1:0] c [4];
    logic signed [Q_W-1:0] r [4];
    logic                  sat;

    always_comb
    begin
        one_q = Q_W'(ONE);
        o0 = side.neg[0] ? -Q_W'(quo[0]) : Q_W'(quo[0]);
        o1 = side.neg[1] ? -Q_W'(quo[1]) : Q_W'(quo[1]);
        o2 = side.neg[2] ? -Q_W'(quo[2]) : Q_W'(quo[2]);
        big = Q_W'(side.qb);
        unique case (side.best)
            BEST_X:
            begin
                c[0] = big; c[1] = o0;  c[2] = o1;  c[3] = o2;
            end
            BEST_Y:
            begin
                c[0] = o0;  c[1] = big; c[2] = o1;  c[3] = o2;
            end
            BEST_Z:
            begin
                c[0] = o0;  c[1] = o1;  c[2] = big; c[3] = o2;
            end
            default:
            begin
                c[0] = o0;  c[1] = o1;  c[2] = o2;  c[3] = big;
            end
        endcase
        // negative w flips the whole quaternion, then clamp to plus or minus one
        sat = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            r[k] = (c[3] < 0) ? -c[k] : c[k];
            if (r[k] > one_q)
            begin
                r[k] = one_q;
                sat  = 1'b1;
            end
            else if (r[k] < -one_q)
            begin
                r[k] = -one_q;
                sat  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_x    <= r[0][IN_W-1:0];
            quat_y    <= r[1][IN_W-1:0];
            quat_z    <= r[2][IN_W-1:0];
            quat_w    <= r[3][W_W-1:0];
            saturated <= sat;
        end
    end

endmodule
`default_nettype wire

FILE: design/rotation_matrix_to_quaternion_unit.sv
// top level of the rotation matrix to quaternion unit
// depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div and rmq_back
`default_nettype none
// Converts one 3x3 rotation matrix (signed Q1.16) per transfer into the unit
// quaternion x, y, z, w with the scalar last and w never negative, by picking
// the largest of the four trace combinations. The unit is a single pipeline
// of 39 register stages: two front stages (combinations and pick), 17 square
// root stages (one root bit each), a rounding-bias stage, 18 divider stages
// (one quotient bit each, three lanes side by side) and the output register.
// A new matrix can be taken every cycle when the output side keeps up. While
// a finished result waits at the output, the whole pipeline holds and
// in_ready is low; nothing is lost or repeated. Matrices that are not
// rotations can push a component past one; it is clamped and saturated is
// set with that result.
module rotation_matrix_to_quaternion_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m00,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m10,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m20,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m01,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m11,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m21,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m02,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m12,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m22,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [rmq_pkg::IN_W-1:0]         quat_x,
    output logic signed [rmq_pkg::IN_W-1:0]         quat_y,
    output logic signed [rmq_pkg::IN_W-1:0]         quat_z,
    output logic [rmq_pkg::W_W-1:0]                 quat_w,
    output logic                                    saturated
);
    import rmq_pkg::*;

    // pipeline advance: the output register is empty or being taken
    logic                 en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // front: combinations, pick of the largest, off-diagonal magnitudes
    logic                 f_valid;
    logic [RAD_W-1:0]     f_rad;
    front_side_t          f_side;

    rmq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .m00      (m00),
        .m10      (m10),
        .m20      (m20),
        .m01      (m01),
        .m11      (m11),
        .m21      (m21),
        .m02      (m02),
        .m12      (m12),
        .m22      (m22),
        .out_valid(f_valid),
        .rad      (f_rad),
        .side     (f_side)
    );

    // square root of the largest combination, carrying the dividends along
    logic                 s_valid;
    logic [ROOT_W-1:0]    s_root;
    front_side_t          s_side;

    rmq_sqrt #(
        .SIDE_W ($bits(front_side_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .rad      (f_rad),
        .side_in  (f_side),
        .out_valid(s_valid),
        .root     (s_root),
        .side_out (s_side)
    );

    // three divisions by the root, rounded to nearest
    div_side_t            d_side_in;
    div_side_t            d_side;
    logic                 d_valid;
    logic [2:0][QUO_W-1:0] d_quo;

    always_comb
    begin
        d_side_in.best = s_side.best;
        d_side_in.neg  = s_side.neg;
        d_side_in.qb   = s_root;
    end

    rmq_div #(
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_valid),
        .mag      (s_side.mag),
        .qb       (s_root),
        .side_in  (d_side_in),
        .out_valid(d_valid),
        .quo      (d_quo),
        .side_out (d_side)
    );

    // placement, sign of w, clamp and output register
    rmq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_valid),
        .side     (d_side),
        .quo      (d_quo),
        .out_valid(out_valid),
        .quat_x   (quat_x),
        .quat_y   (quat_y),
        .quat_z   (quat_z),
        .quat_w   (quat_w),
        .saturated(saturated)
    );

endmodule
`default_nettype wire

FILE: design/rmq_checker.sv
// port-level checks for the rotation matrix to quaternion unit, with its bind
// depends on rmq_pkg and rotation_matrix_to_quaternion_unit
`default_nettype none
module rmq_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m00,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m10,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m20,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m01,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m11,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m21,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m02,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m12,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    m22,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    quat_x,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    quat_y,
    input  wire logic signed [rmq_pkg::IN_W-1:0]    quat_z,
    input  wire logic [rmq_pkg::W_W-1:0]            quat_w,
    input  wire logic                               saturated
);
    import rmq_pkg::*;

    // a waiting matrix holds until its transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(m00) && $stable(m10)
            && $stable(m20) && $stable(m01) && $stable(m11) && $stable(m21)
            && $stable(m02) && $stable(m12) && $stable(m22))
        else $error("input changed while waiting");

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(quat_y)
            && $stable(quat_z) && $stable(quat_w) && $stable(saturated))
        else $error("output changed while stalled");

    // input side is open exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stall");

    // every delivered component lies within plus or minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w <= W_W'(ONE)) && (quat_x <= IN_W'(ONE))
            && (quat_x >= -IN_W'(ONE)) && (quat_y <= IN_W'(ONE))
            && (quat_y >= -IN_W'(ONE)) && (quat_z <= IN_W'(ONE))
            && (quat_z >= -IN_W'(ONE)))
        else $error("component out of range");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);
`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for rotation_matrix_to_quaternion_unit
// depends on rmq_pkg and the unit's rtl; stimulus table, random matrices and a predictor
`default_nettype none
module testbench;

    import rmq_pkg::*;

    localparam int LATENCY    = 39;
    localparam int WATCH_MAX  = 20000;
    localparam int N_RANDOM   = 1880;
    localparam int N_DIRECTED = 12;

    typedef logic signed [IN_W-1:0] entry_t;

    typedef struct {
        entry_t m [9];   // m00 m10 m20 m01 m11 m21 m02 m12 m22
    } matrix_t;

    typedef struct {
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        logic [IN_W-1:0] z;
        logic [W_W-1:0]  w;
        logic            sat;
    } quat_t;

    // row of the directed table; has_quat marks rows with a typed-in result
    typedef struct {
        matrix_t mat;
        bit      has_quat;
        quat_t   quat;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    entry_t m00, m10, m20, m01, m11, m21, m02, m12, m22;
    logic out_valid;
    logic out_ready;
    logic signed [IN_W-1:0] quat_x, quat_y, quat_z;
    logic [W_W-1:0] quat_w;
    logic saturated;

    quat_t pending_quats [$];
    int    errors;
    int    watch_cnt;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    n_sent;
    int    n_checked;
    int    n_saturated;

    rotation_matrix_to_quaternion_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .m00       (m00),
        .m10       (m10),
        .m20       (m20),
        .m01       (m01),
        .m11       (m11),
        .m21       (m21),
        .m02       (m02),
        .m12       (m12),
        .m22       (m22),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .saturated (saturated)
    );

    always #5 clk = ~clk;

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // s / (4 * qb) in fixed point, round half away from zero
    function automatic longint scaled_quotient(longint s, longint unsigned qb);
        longint unsigned mag;
        longint unsigned q;
        mag = longint'(s < 0 ? -s : s) << SHIFT;
        q = (mag + (qb >> 1)) / qb;
        return s < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic quat_t shepperd_quat(matrix_t mt);
        longint a [9];
        longint d [4];
        longint q [4];
        longint one;
        longint unsigned qb;
        int best;
        bit sat;
        quat_t r;
        one = ONE;
        for (int i = 0; i < 9; i++)
            a[i] = longint'(mt.m[i]);
        // a index: 0=m00 1=m10 2=m20 3=m01 4=m11 5=m21 6=m02 7=m12 8=m22
        d[0] = one + a[0] - a[4] - a[8];
        d[1] = one - a[0] + a[4] - a[8];
        d[2] = one - a[0] - a[4] + a[8];
        d[3] = one + a[0] + a[4] + a[8];
        best = 0;
        for (int i = 0; i < 4; i++)
            if (d[i] < 0)
                d[i] = -d[i];
        for (int i = 1; i < 4; i++)
            if (d[i] > d[best])
                best = i;
        qb = int_sqrt(longint'(d[best]) << SHIFT);
        if (qb == 0)
            qb = 1;
        q[best] = longint'(qb);
        case (best)
            BEST_X:
            begin
                q[1] = scaled_quotient(a[3] + a[1], qb);
                q[2] = scaled_quotient(a[6] + a[2], qb);
                q[3] = scaled_quotient(a[7] - a[5], qb);
            end
            BEST_Y:
            begin
                q[0] = scaled_quotient(a[3] + a[1], qb);
                q[2] = scaled_quotient(a[5] + a[7], qb);
                q[3] = scaled_quotient(a[2] - a[6], qb);
            end
            BEST_Z:
            begin
                q[0] = scaled_quotient(a[2] + a[6], qb);
                q[1] = scaled_quotient(a[5] + a[7], qb);
                q[3] = scaled_quotient(a[3] - a[1], qb);
            end
            default:
            begin
                q[0] = scaled_quotient(a[7] - a[5], qb);
                q[1] = scaled_quotient(a[2] - a[6], qb);
                q[2] = scaled_quotient(a[3] - a[1], qb);
            end
        endcase
        if (q[3] < 0)
            for (int i = 0; i < 4; i++)
                q[i] = -q[i];
        sat = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (q[i] > one)
            begin
                q[i] = one;
                sat = 1'b1;
            end
            else if (q[i] < -one)
            begin
                q[i] = -one;
                sat = 1'b1;
            end
        end
        r.x = q[0][IN_W-1:0];
        r.y = q[1][IN_W-1:0];
        r.z = q[2][IN_W-1:0];
        r.w = q[3][W_W-1:0];
        r.sat = sat;
        return r;
    endfunction

    function automatic matrix_t make_matrix(longint e0, longint e1, longint e2,
                                            longint e3, longint e4, longint e5,
                                            longint e6, longint e7, longint e8);
        matrix_t mt;
        mt.m[0] = e0[IN_W-1:0]; mt.m[1] = e1[IN_W-1:0]; mt.m[2] = e2[IN_W-1:0];
        mt.m[3] = e3[IN_W-1:0]; mt.m[4] = e4[IN_W-1:0]; mt.m[5] = e5[IN_W-1:0];
        mt.m[6] = e6[IN_W-1:0]; mt.m[7] = e7[IN_W-1:0]; mt.m[8] = e8[IN_W-1:0];
        return mt;
    endfunction

    // axis-angle rotation built with real math, rounded into Q1.16
    function automatic matrix_t random_rotation();
        real ax, ay, az, n, ang, c, s, t;
        real r [9];
        matrix_t mt;
        ax = $urandom_range(2000) / 1000.0 - 1.0;
        ay = $urandom_range(2000) / 1000.0 - 1.0;
        az = $urandom_range(2000) / 1000.0 - 1.0;
        n = $sqrt(ax * ax + ay * ay + az * az);
        if (n < 1.0e-3)
        begin
            ax = 1.0;
            n = 1.0;
        end
        ax /= n; ay /= n; az /= n;
        ang = $urandom_range(100000) * 3.14159265358979 / 100000.0;
        c = $cos(ang);
        s = $sin(ang);
        t = 1.0 - c;
        r[0] = t * ax * ax + c;      r[3] = t * ax * ay - s * az; r[6] = t * ax * az + s * ay;
        r[1] = t * ax * ay + s * az; r[4] = t * ay * ay + c;      r[7] = t * ay * az - s * ax;
        r[2] = t * ax * az - s * ay; r[5] = t * ay * az + s * ax; r[8] = t * az * az + c;
        for (int i = 0; i < 9; i++)
        begin
            mt.m[i] = entry_t'($rtoi(r[i] * ONE + (r[i] < 0 ? -0.5 : 0.5)));
            // small noise so rounding and tie paths get exercised
            if ($urandom_range(3) == 0)
                mt.m[i] = mt.m[i] + entry_t'($signed($urandom_range(8)) - 4);
        end
        return mt;
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t mt;
        int kind;
        kind = $urandom_range(99);
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 60)
                mt.m[i] = entry_t'($urandom_range(2 * ONE) - ONE);   // stated range
            else
                mt.m[i] = entry_t'($urandom);                        // any 18-bit value
        end
        return mt;
    endfunction

    // one transfer on the input side; valid stays up across back-to-back items
    task automatic send_matrix(matrix_t mt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        m00 <= mt.m[0]; m10 <= mt.m[1]; m20 <= mt.m[2];
        m01 <= mt.m[3]; m11 <= mt.m[4]; m21 <= mt.m[5];
        m02 <= mt.m[6]; m12 <= mt.m[7]; m22 <= mt.m[8];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic push_and_send(matrix_t mt);
        pending_quats.push_back(shepperd_quat(mt));
        send_matrix(mt);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_quats.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, check each transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_quats.size() == 0)
                begin
                    $error("result with no matrix outstanding");
                    errors++;
                end
                else
                begin
                    quat_t e;
                    e = pending_quats.pop_front();
                    n_checked++;
                    if (saturated)
                        n_saturated++;
                    if (quat_x !== e.x)
                    begin
                        $error("quat_x expected %0d got %0d", $signed(e.x), quat_x);
                        errors++;
                    end
                    if (quat_y !== e.y)
                    begin
                        $error("quat_y expected %0d got %0d", $signed(e.y), quat_y);
                        errors++;
                    end
                    if (quat_z !== e.z)
                    begin
                        $error("quat_z expected %0d got %0d", $signed(e.z), quat_z);
                        errors++;
                    end
                    if (quat_w !== e.w)
                    begin
                        $error("quat_w expected %0d got %0d", e.w, quat_w);
                        errors++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated expected %0d got %0d", e.sat, saturated);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            watch_cnt <= 0;
        else
            watch_cnt <= watch_cnt + 1;
        if (watch_cnt >= WATCH_MAX)
        begin
            $display("timeout after %0d idle cycles", WATCH_MAX);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t table_rows [N_DIRECTED];
        int phase;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {m00, m10, m20, m01, m11, m21, m02, m12, m22} = '0;
        errors = 0;
        watch_cnt = 0;
        n_sent = 0;
        n_checked = 0;
        n_saturated = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // directed rows: identity and half-turns read off directly, the rest predicted
        table_rows[0] = '{make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
                          '{0, 0, 0, ONE, 0}};
        table_rows[1] = '{make_matrix(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1,
                          '{ONE, 0, 0, 0, 0}};
        table_rows[2] = '{make_matrix(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE), 1,
                          '{0, ONE, 0, 0, 0}};
        table_rows[3] = '{make_matrix(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE), 1,
                          '{0, 0, ONE, 0, 0}};
        // all zero: every combination ties, x wins
        table_rows[4] = '{make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '{default: 0}};
        // 90 degrees about z, w sign from off-diagonal difference
        table_rows[5] = '{make_matrix(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE), 0, '{default: 0}};
        // negative w through pick of x, forces negation
        table_rows[6] = '{make_matrix(ONE, 0, 0, 0, -ONE, ONE, 0, -ONE, -ONE), 0,
                          '{default: 0}};
        // non-rotation with large off-diagonals
        table_rows[7] = '{make_matrix(ONE, ONE, ONE, -ONE, ONE, ONE, -ONE, -ONE, ONE), 0,
                          '{default: 0}};
        // most negative encodings, outside the stated range
        table_rows[8] = '{make_matrix(-131072, -131072, -131072, -131072, -131072,
                                      -131072, -131072, -131072, -131072), 0, '{default: 0}};
        // largest positive encodings
        table_rows[9] = '{make_matrix(131071, 131071, 131071, 131071, 131071, 131071,
                                      131071, 131071, 131071), 0, '{default: 0}};
        // alternating bit patterns
        table_rows[10] = '{make_matrix(-87382, 87381, -87382, 87381, -87382, 87381,
                                       -87382, 87381, -87382), 0, '{default: 0}};
        table_rows[11] = '{make_matrix(-ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE),
                           0, '{default: 0}};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (table_rows[i].has_quat)
                pending_quats.push_back(table_rows[i].quat);
            else
                pending_quats.push_back(shepperd_quat(table_rows[i].mat));
            send_matrix(table_rows[i].mat);
        end
        drain_pipeline();

        // idle phases: none, sender, receiver, both, then none again
        for (int i = 0; i < N_RANDOM; i++)
        begin
            phase = (i * 5) / N_RANDOM;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3: begin send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if ($urandom_range(99) < 75)
                push_and_send(random_rotation());
            else
                push_and_send(random_matrix());
            // sender waits for everything outstanding now and then
            if (i % 500 == 250)
                drain_pipeline();
        end
        drain_pipeline();
        repeat (LATENCY + 5) @(posedge clk);

        $display("sent %0d matrices (rotations, arbitrary and out-of-range encodings)",
                 n_sent);
        $display("checked %0d quaternions, %0d saturated", n_checked, n_saturated);
        if (errors == 0 && pending_quats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
